[sv/dlt_pkg.sv]
// types and constants shared by the lease table modules
`default_nettype none
package dlt_pkg;
	localparam int MAC_W = 48;
	localparam int IP_W  = 32;

	typedef enum logic [1:0] {
		OP_OFFER    = 2'd0,
		OP_REQUEST  = 2'd1,
		OP_RELEASE  = 2'd2,
		OP_VALIDATE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOMATCH   = 3'd1,
		ST_OFF       = 3'd2,
		ST_EXHAUSTED = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		LS_OPEN    = 2'd0,
		LS_OFFERED = 2'd1,
		LS_TAKEN   = 2'd2
	} lease_state_t;

	typedef enum logic [2:0] {
		REG_PREFIX    = 3'd0,
		REG_MASK      = 3'd1,
		REG_MODE      = 3'd2,
		REG_DEV_START = 3'd3,
		REG_DEV_END   = 3'd4,
		REG_PC_START  = 3'd5,
		REG_PC_END    = 3'd6,
		REG_LEASE     = 3'd7
	} reg_idx_t;

	localparam logic [1:0] MODE_NORMAL    = 2'd0;
	localparam logic [1:0] MODE_DUPLICATE = 2'd1;

	localparam logic [MAC_W-1:0] PREFIX_RST = 48'h0003_F400_0000;
	localparam logic [MAC_W-1:0] MASK_RST   = 48'hFFFF_FF00_0000;
	localparam logic [IP_W-1:0]  LEASE_RST  = 32'd3600;
endpackage
`default_nettype wire

[sv/dhcp_lease_table.sv]
// lease table top level: config registers, entry memories and scan sequencer
// each scan reads the live entries in order; memory data passes the read address register, then the read data register
// each item makes up to three scans: lookup, address/highest search, least-expiry search
// throughput: one item at a time; input is ready again in the cycle after the result is accepted
// reset: registers take their defaults and the fill count clears; memories need no clearing
`default_nettype none
module dhcp_lease_table import dlt_pkg::*; #(
	parameter int TABLE_ENTRIES = 256
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// operation[1:0], hw_addr[49:2], client_ip[81:50], now_seconds[113:82], zero fill
	input  wire logic [119:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// status[2:0], granted_ip[34:3], lease_duration[66:35], zero fill
	output logic [71:0]       m_tdata,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [47:0]  cfg_data
);
	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_FIND  = 9'b000000010,
		S_DEC   = 9'b000000100,
		S_SCAN2 = 9'b000001000,
		S_DEC2  = 9'b000010000,
		S_SCAN3 = 9'b000100000,
		S_DEC3  = 9'b001000000,
		S_APPLY = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t state_q;

	logic [MAC_W-1:0] prefix_q, mask_q;
	logic [1:0]       mode_q;
	logic [IP_W-1:0]  dstart_q, dend_q, pstart_q, pend_q, lease_q;

	logic [MAC_W-1:0] mac_mem [TABLE_ENTRIES];
	logic [IP_W-1:0]  ip_mem  [TABLE_ENTRIES];
	logic [IP_W-1:0]  exp_mem [TABLE_ENTRIES];
	logic [1:0]       ls_mem  [TABLE_ENTRIES];

	logic [CW-1:0]    used_q;
	logic [CW-1:0]    idx_q;
	logic             rd_vld_q;
	logic [AW-1:0]    rd_addr_q;
	logic             rd_dv_q;
	logic [AW-1:0]    rd_tag_q;
	logic [MAC_W-1:0] rd_mac_q;
	logic [IP_W-1:0]  rd_ip_q, rd_exp_q;

	logic [1:0]       op_q;
	logic [MAC_W-1:0] mac_q;
	logic [IP_W-1:0]  req_q, now_q;
	logic             dev_q;
	logic             found_q;
	logic [AW-1:0]    eidx_q;
	logic [IP_W-1:0]  eip_q;
	logic             held_q;
	logic [IP_W-1:0]  top_q;
	logic             best_vld_q;
	logic [AW-1:0]    best_q;
	logic [IP_W-1:0]  best_exp_q;
	logic [IP_W-1:0]  best_ip_q;

	logic [2:0]       st_q;
	logic [IP_W-1:0]  gip_q, dur_q;

	// write request built in the decision states and, for new entries, in the apply state
	logic             wr_q;
	logic [AW-1:0]    wa_q;
	logic             wmac_q, wip_q, wexp_q, wls_q, inc_q;
	logic [IP_W-1:0]  wipd_q, wexpd_q;
	logic [1:0]       wlsd_q;

	logic dev_in;
	logic rd_dev;
	logic [IP_W-1:0] pstart, pend;
	logic [IP_W:0]   nexti;
	logic [IP_W:0]   sum;

	assign dev_in = ((s_tdata[49:2] ^ prefix_q) & mask_q) == '0;
	assign rd_dev = ((rd_mac_q ^ prefix_q) & mask_q) == '0;
	assign pstart = dev_q ? dstart_q : pstart_q;
	assign pend   = dev_q ? dend_q : pend_q;
	assign nexti  = {1'b0, top_q} + 1'b1;
	assign sum    = {1'b0, now_q} + {1'b0, lease_q};

	assign s_tready  = state_q == S_IDLE;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = state_q == S_OUT;
	assign m_tdata   = {5'd0, dur_q, gip_q, st_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= PREFIX_RST;
			mask_q   <= MASK_RST;
			mode_q   <= MODE_NORMAL;
			dstart_q <= '0;
			dend_q   <= '0;
			pstart_q <= '0;
			pend_q   <= '0;
			lease_q  <= LEASE_RST;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PREFIX:    prefix_q <= cfg_data;
				REG_MASK:      mask_q   <= cfg_data;
				REG_MODE:      mode_q   <= cfg_data[1:0];
				REG_DEV_START: dstart_q <= cfg_data[31:0];
				REG_DEV_END:   dend_q   <= cfg_data[31:0];
				REG_PC_START:  pstart_q <= cfg_data[31:0];
				REG_PC_END:    pend_q   <= cfg_data[31:0];
				REG_LEASE:     lease_q  <= cfg_data[31:0];
				default:       lease_q  <= lease_q;
			endcase
		end
	end

	// memories: one write port each; the mac, ip and expiry memories also have one read port
	always_ff @(posedge clk) begin
		rd_mac_q <= mac_mem[rd_addr_q];
		rd_ip_q  <= ip_mem[rd_addr_q];
		rd_exp_q <= exp_mem[rd_addr_q];
		if (state_q == S_APPLY && wr_q) begin
			if (wmac_q) mac_mem[wa_q] <= mac_q;
			if (wip_q)  ip_mem[wa_q]  <= wipd_q;
			if (wexp_q) exp_mem[wa_q] <= wexpd_q;
			if (wls_q)  ls_mem[wa_q]  <= wlsd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			used_q   <= '0;
			rd_vld_q <= 1'b0;
			rd_dv_q  <= 1'b0;
			idx_q    <= '0;
		end else begin
			// read data tag, aligned with the registered memory outputs
			rd_dv_q  <= rd_vld_q;
			rd_tag_q <= rd_addr_q;
			unique case (state_q)
				S_IDLE: begin
					rd_vld_q <= 1'b0;
					if (s_tvalid) begin
						op_q    <= s_tdata[1:0];
						mac_q   <= s_tdata[49:2];
						req_q   <= s_tdata[81:50];
						now_q   <= s_tdata[113:82];
						dev_q   <= dev_in;
						found_q <= 1'b0;
						held_q  <= 1'b0;
						wr_q    <= 1'b0;
						wmac_q  <= 1'b0;
						wip_q   <= 1'b0;
						wexp_q  <= 1'b0;
						wls_q   <= 1'b0;
						inc_q   <= 1'b0;
						idx_q   <= '0;
						state_q <= S_FIND;
					end
				end
				S_FIND: begin
					// issue reads, compare the data of the tagged address
					if (rd_dv_q && !found_q && mac_q != '0 && rd_mac_q == mac_q) begin
						found_q <= 1'b1;
						eidx_q  <= rd_tag_q;
						eip_q   <= rd_ip_q;
					end
					if (idx_q < used_q) begin
						rd_addr_q <= idx_q[AW-1:0];
						rd_vld_q  <= 1'b1;
						idx_q     <= idx_q + 1'b1;
					end else begin
						rd_vld_q <= 1'b0;
						if (!rd_vld_q) state_q <= S_DEC;
					end
				end
				S_DEC: begin
					st_q  <= ST_NOMATCH;
					gip_q <= '0;
					dur_q <= '0;
					wa_q  <= eidx_q;
					idx_q <= '0;
					top_q <= pstart;
					state_q <= S_APPLY;
					if (op_q == OP_OFFER) begin
						if (found_q) begin
							st_q <= ST_OK; gip_q <= eip_q; dur_q <= lease_q;
							wr_q <= 1'b1; wexp_q <= 1'b1; wexpd_q <= now_q;
							wls_q <= 1'b1; wlsd_q <= LS_OFFERED;
						end else if (mac_q == '0) begin
							st_q <= ST_NOMATCH;
						end else if (dev_q && mode_q[1]) begin
							st_q <= ST_OFF;
						end else if (dev_q && mode_q == MODE_DUPLICATE) begin
							gip_q <= dstart_q;
							inc_q <= 1'b1;
						end else begin
							state_q <= S_SCAN2;
						end
					end else if (found_q && eip_q == req_q) begin
						st_q <= ST_OK; gip_q <= req_q;
						if (op_q == OP_REQUEST) begin
							dur_q <= lease_q;
							wr_q <= 1'b1; wls_q <= 1'b1; wlsd_q <= LS_TAKEN;
							wexp_q <= 1'b1;
							wexpd_q <= sum[IP_W] ? '1 : sum[IP_W-1:0];
						end else if (op_q == OP_RELEASE) begin
							wr_q <= 1'b1; wls_q <= 1'b1; wlsd_q <= LS_OPEN;
						end
					end else if (op_q == OP_REQUEST && found_q) begin
						wr_q <= 1'b1; wls_q <= 1'b1; wlsd_q <= LS_OPEN;
					end
				end
				S_SCAN2: begin
					if (rd_dv_q) begin
						if (rd_ip_q == req_q) held_q <= 1'b1;
						if (rd_dev == dev_q && rd_ip_q > top_q) top_q <= rd_ip_q;
					end
					if (idx_q < used_q) begin
						rd_addr_q <= idx_q[AW-1:0];
						rd_vld_q  <= 1'b1;
						idx_q     <= idx_q + 1'b1;
					end else begin
						rd_vld_q <= 1'b0;
						if (!rd_vld_q) state_q <= S_DEC2;
					end
				end
				S_DEC2: begin
					idx_q      <= '0;
					best_vld_q <= 1'b0;
					if (req_q != '0 && req_q >= pstart && req_q <= pend && !held_q) begin
						gip_q <= req_q; inc_q <= 1'b1; state_q <= S_APPLY;
					end else if (top_q == '0) begin
						gip_q <= '0; inc_q <= 1'b1; state_q <= S_APPLY;
					end else if (nexti > {1'b0, pend}) begin
						state_q <= S_SCAN3;
					end else begin
						gip_q <= nexti[IP_W-1:0]; inc_q <= 1'b1; state_q <= S_APPLY;
					end
				end
				S_SCAN3: begin
					if (rd_dv_q && rd_dev == dev_q &&
					    (!best_vld_q || rd_exp_q < best_exp_q)) begin
						best_vld_q <= 1'b1;
						best_q     <= rd_tag_q;
						best_exp_q <= rd_exp_q;
						best_ip_q  <= rd_ip_q;
					end
					if (idx_q < used_q) begin
						rd_addr_q <= idx_q[AW-1:0];
						rd_vld_q  <= 1'b1;
						idx_q     <= idx_q + 1'b1;
					end else begin
						rd_vld_q <= 1'b0;
						if (!rd_vld_q) state_q <= S_DEC3;
					end
				end
				S_DEC3: begin
					// reuse keeps the entry's address and takes over its mac
					if (best_vld_q && (best_exp_q == '0 || best_exp_q < now_q)) begin
						wa_q <= best_q;
						wr_q <= 1'b1; wmac_q <= 1'b1;
						wexp_q <= 1'b1; wexpd_q <= now_q;
						wls_q <= 1'b1; wlsd_q <= LS_OFFERED;
						st_q <= ST_OK; dur_q <= lease_q;
						gip_q <= best_ip_q;
					end else begin
						st_q <= ST_EXHAUSTED;
					end
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (inc_q) begin
						if (used_q >= FULL) begin
							st_q <= ST_FULL; gip_q <= '0;
						end else begin
							st_q <= ST_OK; dur_q <= lease_q;
							wa_q <= used_q[AW-1:0];
							wr_q <= 1'b1; wmac_q <= 1'b1; wip_q <= 1'b1;
							wipd_q <= gip_q; wexp_q <= 1'b1; wexpd_q <= now_q;
							wls_q <= 1'b1; wlsd_q <= LS_OFFERED;
							used_q <= used_q + 1'b1;
						end
						inc_q <= 1'b0;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					wr_q <= 1'b0;
					if (m_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[tb/tb_dhcp_lease_table.sv]
// testbench for the address lease table: predictor, stream drivers and reply checking
`timescale 1ns / 1ps
`default_nettype none
module tb_dhcp_lease_table;
	import dlt_pkg::*;

	localparam int DEPTH = 256;
	localparam int SETTLE = 3 * DEPTH + 16;
	localparam longint LIMIT = 3000000;

	typedef struct packed {
		status_t     status;
		logic [31:0] granted;
		logic [31:0] duration;
	} reply_t;

	class lease_predictor;
		logic [47:0] prefix, mask;
		logic [1:0]  mode;
		logic [31:0] dev_start, dev_end, pc_start, pc_end, lease;
		logic [47:0] mac_tab[DEPTH];
		logic [31:0] ip_tab[DEPTH];
		logic [31:0] expiry_tab[DEPTH];
		lease_state_t state_tab[DEPTH];
		int          used;
		reply_t      pending_replies[$];
		int          mismatches;
		int          replies_seen;

		function new();
			prefix = PREFIX_RST;
			mask = MASK_RST;
			mode = MODE_NORMAL;
			dev_start = 0;
			dev_end = 0;
			pc_start = 0;
			pc_end = 0;
			lease = LEASE_RST;
			used = 0;
			mismatches = 0;
			replies_seen = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [47:0] val);
			case (idx)
				REG_PREFIX:    prefix = val;
				REG_MASK:      mask = val;
				REG_MODE:      mode = val[1:0];
				REG_DEV_START: dev_start = val[31:0];
				REG_DEV_END:   dev_end = val[31:0];
				REG_PC_START:  pc_start = val[31:0];
				REG_PC_END:    pc_end = val[31:0];
				REG_LEASE:     lease = val[31:0];
			endcase
		endfunction

		function bit is_dev(logic [47:0] mac);
			return ((mac ^ prefix) & mask) == 48'd0;
		endfunction

		function int lookup(logic [47:0] mac);
			if (mac == 0) return -1;
			for (int i = 0; i < used; i++)
				if (mac_tab[i] == mac) return i;
			return -1;
		endfunction

		function bit held(logic [31:0] ip);
			for (int i = 0; i < used; i++)
				if (ip_tab[i] == ip) return 1;
			return 0;
		endfunction

		// returns an entry index, or minus the failure status
		function int allocate(logic [47:0] mac, logic [31:0] req, logic [31:0] now);
			bit          dev;
			logic [31:0] lo, hi, ip, top;
			logic [32:0] nxt;
			int          best;
			dev = is_dev(mac);
			lo = dev ? dev_start : pc_start;
			hi = dev ? dev_end : pc_end;
			if (dev && mode >= 2) return -int'(ST_OFF);
			if (dev && mode == MODE_DUPLICATE) begin
				ip = lo;
			end else if (req != 0 && req >= lo && req <= hi && !held(req)) begin
				ip = req;
			end else begin
				top = lo;
				for (int i = 0; i < used; i++)
					if (is_dev(mac_tab[i]) == dev && ip_tab[i] > top) top = ip_tab[i];
				nxt = {1'b0, top} + 33'd1;
				if (top == 0) begin
					ip = 0;
				end else if (nxt > {1'b0, hi}) begin
					best = -1;
					for (int i = 0; i < used; i++)
						if (is_dev(mac_tab[i]) == dev &&
							(best < 0 || expiry_tab[i] < expiry_tab[best])) best = i;
					if (best < 0) return -int'(ST_EXHAUSTED);
					if (expiry_tab[best] == 0 || expiry_tab[best] < now) begin
						mac_tab[best] = mac;
						return best;
					end
					return -int'(ST_EXHAUSTED);
				end else begin
					ip = nxt[31:0];
				end
			end
			if (used >= DEPTH) return -int'(ST_FULL);
			mac_tab[used] = mac;
			ip_tab[used] = ip;
			expiry_tab[used] = 0;
			state_tab[used] = LS_OFFERED;
			used++;
			return used - 1;
		endfunction

		function reply_t note_item(op_t op, logic [47:0] mac, logic [31:0] ip,
				logic [31:0] now);
			reply_t      r;
			int          e;
			logic [32:0] sum;
			r = '{ST_NOMATCH, 32'd0, 32'd0};
			e = lookup(mac);
			if (op == OP_OFFER) begin
				if (e < 0 && mac != 0) begin
					e = allocate(mac, ip, now);
					if (e < 0) r.status = status_t'(-e);
				end
				if (e >= 0) begin
					state_tab[e] = LS_OFFERED;
					expiry_tab[e] = now;
					r = '{ST_OK, ip_tab[e], lease};
				end
			end else if (e >= 0 && ip_tab[e] == ip) begin
				r.status = ST_OK;
				r.granted = ip;
				if (op == OP_REQUEST) begin
					sum = {1'b0, now} + {1'b0, lease};
					state_tab[e] = LS_TAKEN;
					expiry_tab[e] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
					r.duration = lease;
				end else if (op == OP_RELEASE) begin
					state_tab[e] = LS_OPEN;
				end
			end else if (op == OP_REQUEST && e >= 0) begin
				state_tab[e] = LS_OPEN;
			end
			pending_replies.push_back(r);
			return r;
		endfunction

		function void check_reply(logic [71:0] data);
			reply_t got, want;
			got = '{status_t'(data[2:0]), data[34:3], data[66:35]};
			replies_seen++;
			if (pending_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected reply: status %0d ip %h lease %0d",
						got.status, got.granted, got.duration);
				return;
			end
			want = pending_replies.pop_front();
			if (got != want || data[71:67] != 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("reply %0d: expected %0d/%h/%0d got %0d/%h/%0d",
						replies_seen, want.status, want.granted, want.duration,
						got.status, got.granted, got.duration);
			end
		endfunction
	endclass

	logic         clk, arst_n;
	logic         s_tvalid, s_tready, m_tvalid, m_tready;
	logic [119:0] s_tdata;
	logic [71:0]  m_tdata;
	logic         cfg_valid, cfg_ready;
	logic [2:0]   cfg_index;
	logic [47:0]  cfg_data;

	lease_predictor pred;
	longint         cycles;
	int             burst_left, items_sent, offers_ok;
	bit             gaps_on, stalls_on;
	logic [47:0]    macs[32];
	logic [31:0]    last_ip[32];
	logic [31:0]    clock_now;

	dhcp_lease_table #(.TABLE_ENTRIES(DEPTH)) dut (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_PREFIX;
		cfg_data = '0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// receiver: windows of free flow or of random stalls, chosen at random
	always @(posedge clk) begin
		if (cycles % 3000 == 0) stalls_on <= $urandom_range(0, 2) != 0;
		m_tready <= stalls_on ? ($urandom_range(0, 3) != 0) : 1'b1;
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready) pred.check_reply(m_tdata);

	task automatic write_cfg(reg_idx_t idx, logic [47:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		pred.write_reg(idx, val);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (pred.pending_replies.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_item(op_t op, logic [47:0] mac, logic [31:0] ip,
			logic [31:0] now, output reply_t r);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, now, ip, mac, op};
		do @(posedge clk); while (!s_tready);
		r = pred.note_item(op, mac, ip, now);
		items_sent++;
		if (op == OP_OFFER && r.status == ST_OK) offers_ok++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			gap = gaps_on ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic random_item;
		int          k, pick;
		op_t         op;
		logic [47:0] mac;
		logic [31:0] ip;
		reply_t      r;
		pick = $urandom_range(0, 99);
		op = pick < 40 ? OP_OFFER : pick < 65 ? OP_REQUEST : pick < 80 ? OP_RELEASE
			: OP_VALIDATE;
		k = $urandom_range(0, 31);
		pick = $urandom_range(0, 99);
		mac = pick < 85 ? macs[k] : pick < 90 ? 48'd0 : 48'({$urandom, $urandom});
		pick = $urandom_range(0, 99);
		if (pick < 60) ip = last_ip[k];
		else if (pick < 75) ip = 32'd0;
		else if (pick < 90) ip = pred.pc_start + $urandom_range(0, 8);
		else ip = $urandom;
		if ($urandom_range(0, 19) == 0) clock_now = $urandom;
		else clock_now = clock_now + $urandom_range(0, 300);
		send_item(op, mac, ip, clock_now, r);
		if (mac == macs[k] && r.status == ST_OK) last_ip[k] = r.granted;
	endtask

	task automatic pool(logic [31:0] ds, logic [31:0] de, logic [31:0] ps,
			logic [31:0] pe);
		write_cfg(REG_DEV_START, ds);
		write_cfg(REG_DEV_END, de);
		write_cfg(REG_PC_START, ps);
		write_cfg(REG_PC_END, pe);
	endtask

	initial begin
		reply_t r;
		pred = new();
		cycles = 0;
		burst_left = 0;
		items_sent = 0;
		offers_ok = 0;
		gaps_on = 1'b1;
		stalls_on = 1'b0;
		clock_now = 32'd1000;
		for (int i = 0; i < 32; i++) begin
			macs[i] = i < 16 ? {24'h0003F4, 8'(i), 16'($urandom)}
				: 48'({$urandom, $urandom});
			if (macs[i] == 0) macs[i] = 48'd1;
			last_ip[i] = 0;
		end
		macs[31] = 48'hFFFF_FFFF_FFFF;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default registers: every pool is zero, so new clients receive address zero
		send_item(OP_OFFER, macs[0], 32'd5, 32'd0, r);
		send_item(OP_OFFER, macs[20], 32'd0, 32'd10, r);
		send_item(OP_OFFER, macs[20], 32'hFFFF_FFFF, 32'hFFFF_FFFF, r);
		send_item(OP_REQUEST, macs[0], 32'd0, 32'hFFFF_FFFF, r);
		send_item(OP_REQUEST, macs[20], 32'd7, 32'd20, r);
		send_item(OP_VALIDATE, macs[0], 32'd0, 32'd20, r);
		send_item(OP_RELEASE, macs[0], 32'd0, 32'd30, r);
		send_item(OP_RELEASE, macs[21], 32'd0, 32'd30, r);
		send_item(OP_VALIDATE, macs[21], 32'd0, 32'd30, r);
		send_item(OP_OFFER, 48'd0, 32'd0, 32'd40, r);
		send_item(OP_REQUEST, 48'd0, 32'd0, 32'd40, r);
		send_item(OP_OFFER, macs[31], 32'hFFFF_FFFF, 32'd50, r);
		drain();

		// small pools: exhaustion and expiry takeover
		write_cfg(REG_PREFIX, PREFIX_RST);
		write_cfg(REG_MASK, MASK_RST);
		write_cfg(REG_MODE, MODE_NORMAL);
		write_cfg(REG_LEASE, 32'd100);
		pool(32'd10, 32'd13, 32'd100, 32'd104);
		send_item(OP_OFFER, macs[1], 32'd12, clock_now, r);
		send_item(OP_OFFER, macs[22], 32'd12, clock_now, r);
		send_item(OP_OFFER, macs[23], 32'd104, clock_now, r);
		send_item(OP_REQUEST, macs[23], 32'd104, clock_now, r);
		send_item(OP_OFFER, macs[24], 32'd500, clock_now, r);
		gaps_on = 1'b0;
		repeat (70) random_item();
		gaps_on = 1'b1;
		repeat (80) random_item();
		drain();

		// duplicate mode, zero lease, pool at the top of the address space
		write_cfg(REG_MODE, MODE_DUPLICATE);
		write_cfg(REG_LEASE, 32'd0);
		pool(32'd20, 32'd30, 32'hFFFF_FFFD, 32'hFFFF_FFFF);
		repeat (80) random_item();
		drain();

		// device class off, then the unused mode code, with the longest lease
		write_cfg(REG_MODE, 2'd2);
		write_cfg(REG_LEASE, 32'hFFFF_FFFF);
		repeat (40) random_item();
		drain();
		write_cfg(REG_MODE, 2'd3);
		repeat (40) random_item();
		drain();

		// empty mask makes every client a device
		write_cfg(REG_PREFIX, 48'hFFFF_FFFF_FFFF);
		write_cfg(REG_MASK, 48'd0);
		write_cfg(REG_MODE, MODE_NORMAL);
		write_cfg(REG_LEASE, 32'd1);
		pool(32'd200, 32'd210, 32'd0, 32'd0);
		repeat (60) random_item();
		drain();

		// full mask, wide pool: fill the table and go past it
		write_cfg(REG_PREFIX, 48'({$urandom, $urandom}));
		write_cfg(REG_MASK, 48'hFFFF_FFFF_FFFF);
		write_cfg(REG_LEASE, 32'd600);
		pool(32'd0, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFF0);
		while (pred.used < DEPTH)
			send_item(OP_OFFER, 48'({$urandom, $urandom}) | 48'd1, $urandom, clock_now, r);
		repeat (10)
			send_item(OP_OFFER, 48'({$urandom, $urandom}) | 48'd1, 32'd0, clock_now, r);
		repeat (20) random_item();
		drain();

		$display("%0d items sent, %0d replies checked, %0d successful offers",
			items_sent, pred.replies_seen, offers_ok);
		$display("covered default, small, top-of-space and masked pools, all modes, full table");
		if (pred.mismatches == 0 && pred.pending_replies.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches, %0d replies missing", pred.mismatches,
				pred.pending_replies.size());
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule
`default_nettype wire

[sim.f]
sv/dlt_pkg.sv
sv/dhcp_lease_table.sv
tb/tb_dhcp_lease_table.sv
